[hdl/rsrb_pkg.sv]
package rsrb_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SKIP,
        ST_READ,
        ST_DRAIN
    } rsrb_state_t;

    localparam logic [2:0] KIND_DELIVERED = 3'd0;
    localparam logic [2:0] KIND_LATE      = 3'd1;
    localparam logic [2:0] KIND_DUP       = 3'd2;
    localparam logic [2:0] KIND_BEYOND    = 3'd3;
    localparam logic [2:0] KIND_CLOSED    = 3'd4;

    localparam logic REQ_PACKET = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BUFFER_TIMEOUT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STREAM_TIMEOUT = 2'd1;

    localparam logic [15:0] BUFFER_TIMEOUT_RESET = 16'd1;
    localparam logic [31:0] STREAM_TIMEOUT_RESET = 32'd180;

    typedef struct packed {
        logic       capture;
        logic       emit;
        logic [2:0] emit_kind;
        logic       emit_last;
        logic       from_slot;
        logic       open_set;
        logic       close;
        logic       step;
        logic       take_slot;
        logic       store;
        logic       arm;
        logic       tick_dec;
    } rsrb_cmd_t;

    typedef struct packed {
        logic req_type;
        logic d_zero;
        logic late;
        logic beyond;
        logic dup;
        logic open;
        logic running;
        logic left_gt1;
        logic count_zero;
        logic next_full;
        logic head_full;
        logic out_free;
    } rsrb_sts_t;

endpackage

[hdl/rsrb_ctrl.sv]
module rsrb_ctrl
    import rsrb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  rsrb_sts_t   sts,
    output rsrb_cmd_t   cmd,
    output rsrb_state_t state
);

    rsrb_state_t state_reg;
    rsrb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.req_type == REQ_PACKET)
                begin
                    priority if (sts.d_zero)
                    begin
                        if (sts.out_free)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = KIND_DELIVERED;
                            cmd.emit_last = !sts.next_full;
                            cmd.open_set  = 1'b1;
                            cmd.step      = 1'b1;
                            if (sts.next_full)
                            begin
                                state_next = ST_READ;
                            end
                            else
                            begin
                                cmd.arm    = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                    end
                    else if (sts.late || sts.beyond || sts.dup)
                    begin
                        if (sts.out_free)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_last = 1'b1;
                            cmd.emit_kind = sts.late ? KIND_LATE :
                                            (sts.beyond ? KIND_BEYOND : KIND_DUP);
                            state_next    = ST_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.store  = 1'b1;
                        cmd.arm    = sts.count_zero;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    priority if (!sts.open || !sts.running)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (sts.left_gt1)
                    begin
                        cmd.tick_dec = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else if (sts.count_zero)
                    begin
                        if (sts.out_free)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = KIND_CLOSED;
                            cmd.emit_last = 1'b1;
                            cmd.close     = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.step   = 1'b1;
                        state_next = ST_SKIP;
                    end
                end
            end
            ST_SKIP:
            begin
                // advance to the lowest waiting slot
                if (sts.head_full)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_READ:
            begin
                state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_DELIVERED;
                    cmd.emit_last = !sts.next_full;
                    cmd.from_slot = 1'b1;
                    cmd.take_slot = 1'b1;
                    cmd.step      = 1'b1;
                    if (sts.next_full)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        cmd.arm    = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/rsrb_dp.sv]
module rsrb_dp
    import rsrb_pkg::*;
#(
    parameter int WINDOW      = 64,
    parameter int HANDLE_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]               cfg_data,
    input  logic                      req_type,
    input  logic [15:0]               seq_number,
    input  logic [HANDLE_BITS-1:0]    packet_handle,
    input  rsrb_cmd_t                 cmd,
    output rsrb_sts_t                 sts,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [HANDLE_BITS-1:0]    out_handle,
    output logic [15:0]               out_seq,
    output logic [2:0]                out_kind,
    output logic                      out_last
);

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);

    logic [15:0]             buf_timeout_reg;
    logic [31:0]             stream_timeout_reg;
    logic                    req_type_reg;
    logic [15:0]             seq_reg;
    logic [HANDLE_BITS-1:0]  handle_reg;
    logic                    open_reg;
    logic [15:0]             exp_reg;
    logic [IW-1:0]           head_reg;
    logic [WINDOW-1:0]       full_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [31:0]             left_reg;
    logic                    running_reg;
    logic [HANDLE_BITS-1:0]  mem [WINDOW];
    logic [HANDLE_BITS-1:0]  rd_reg;
    logic                    out_valid_reg;
    logic [HANDLE_BITS-1:0]  out_handle_reg;
    logic [15:0]             out_seq_reg;
    logic [2:0]              out_kind_reg;
    logic                    out_last_reg;

    logic [15:0]             exp_eff;
    logic [15:0]             seq_gap;
    logic                    beyond;
    logic [IW:0]             phys_sum;
    logic [IW-1:0]           phys;
    logic [IW-1:0]           head_inc;

    assign exp_eff  = open_reg ? exp_reg : seq_reg;
    assign seq_gap  = seq_reg - exp_eff;
    assign beyond   = !seq_gap[15] && (seq_gap >= 16'(WINDOW));
    assign phys_sum = {1'b0, head_reg} + {1'b0, seq_gap[IW-1:0]};
    assign phys     = (phys_sum >= (IW+1)'(WINDOW)) ? IW'(phys_sum - (IW+1)'(WINDOW))
                                                   : phys_sum[IW-1:0];
    assign head_inc = (head_reg == IW'(WINDOW - 1)) ? '0 : head_reg + IW'(1);
    assign count_next = count_reg + CW'(cmd.store) - CW'(cmd.take_slot);

    always_comb
    begin
        sts            = '0;
        sts.req_type   = req_type_reg;
        sts.d_zero     = (seq_gap == 16'd0);
        sts.late       = seq_gap[15];
        sts.beyond     = beyond;
        sts.dup        = !seq_gap[15] && !beyond && full_reg[phys];
        sts.open       = open_reg;
        sts.running    = running_reg;
        sts.left_gt1   = (left_reg > 32'd1);
        sts.count_zero = (count_reg == '0);
        sts.next_full  = full_reg[head_inc];
        sts.head_full  = full_reg[head_reg];
        sts.out_free   = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_timeout_reg    <= BUFFER_TIMEOUT_RESET;
            stream_timeout_reg <= STREAM_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_BUFFER_TIMEOUT)
            begin
                buf_timeout_reg <= cfg_data[15:0];
            end
            if (cfg_index == CFG_STREAM_TIMEOUT)
            begin
                stream_timeout_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            seq_reg    <= seq_number;
            handle_reg <= packet_handle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_type_reg <= REQ_PACKET;
            open_reg     <= 1'b0;
            exp_reg      <= '0;
            head_reg     <= '0;
            full_reg     <= '0;
            count_reg    <= '0;
            left_reg     <= '0;
            running_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                req_type_reg <= req_type;
            end
            if (cmd.open_set)
            begin
                open_reg <= 1'b1;
            end
            if (cmd.close)
            begin
                open_reg    <= 1'b0;
                running_reg <= 1'b0;
                left_reg    <= '0;
            end
            if (cmd.step)
            begin
                exp_reg  <= exp_eff + 16'd1;
                head_reg <= head_inc;
            end
            if (cmd.take_slot)
            begin
                full_reg[head_reg] <= 1'b0;
            end
            if (cmd.store)
            begin
                full_reg[phys] <= 1'b1;
            end
            count_reg <= count_next;
            if (cmd.arm)
            begin
                running_reg <= 1'b1;
                left_reg    <= (count_next != '0) ? {16'd0, buf_timeout_reg}
                                                  : stream_timeout_reg;
            end
            else if (cmd.tick_dec)
            begin
                left_reg <= left_reg - 32'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[phys] <= handle_reg;
        end
        rd_reg <= mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_kind_reg <= cmd.emit_kind;
            out_last_reg <= cmd.emit_last;
            priority if (cmd.from_slot)
            begin
                out_handle_reg <= rd_reg;
                out_seq_reg    <= exp_reg;
            end
            else if (cmd.emit_kind == KIND_CLOSED)
            begin
                out_handle_reg <= '0;
                out_seq_reg    <= exp_reg;
            end
            else
            begin
                out_handle_reg <= handle_reg;
                out_seq_reg    <= seq_reg;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_handle = out_handle_reg;
    assign out_seq    = out_seq_reg;
    assign out_kind   = out_kind_reg;
    assign out_last   = out_last_reg;

endmodule

[hdl/rtp_sequence_reorder_buffer.sv]
// An accepted beat is decided in the execute state; its first result beat is registered
// when the output is free. One item at a time; a release drain takes each buffered packet
// through the memory read and drain states; a timeout skip steps over each empty slot.
// Reset: asynchronous, active low; clears stream state, slot valid bits and the timer,
// and loads buffer_timeout_ticks = 1 and stream_timeout_ticks = 180. No clearing pass.
module rtp_sequence_reorder_buffer
    import rsrb_pkg::*;
#(
    parameter int WINDOW      = 64,
    parameter int HANDLE_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]               cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      req_type,
    input  logic [15:0]               seq_number,
    input  logic [HANDLE_BITS-1:0]    packet_handle,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [HANDLE_BITS-1:0]    out_handle,
    output logic [15:0]               out_seq,
    output logic [2:0]                out_kind,
    output logic                      out_last
);

    rsrb_cmd_t   cmd;
    rsrb_sts_t   sts;
    rsrb_state_t state;

    rsrb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd),
        .state    (state)
    );

    rsrb_dp #(
        .WINDOW      (WINDOW),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_type      (req_type),
        .seq_number    (seq_number),
        .packet_handle (packet_handle),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_handle    (out_handle),
        .out_seq       (out_seq),
        .out_kind      (out_kind),
        .out_last      (out_last)
    );

    // never overwrite a result beat that is still waiting
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result overwritten");

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second beat accepted while busy");

    // a store never lands on a full or current slot
    a_store_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> (!sts.dup && !sts.d_zero && !sts.late && !sts.beyond))
        else $error("bad store");

    // draining only reads a full slot
    a_drain_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state == ST_DRAIN) |-> sts.head_full)
        else $error("drain on empty slot");

endmodule

[bench/tb_top.sv]
module tb_top;
    import rsrb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN = 64;
    localparam int STALL_LIMIT = 20000;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_IDX = 2'd3;

    typedef struct packed {
        logic [15:0] handle;
        logic [15:0] seq;
        logic [2:0]  kind;
        logic        last;
    } reorder_beat_t;

    class reorder_scoreboard;
        logic [15:0]   buf_timeout;
        logic [31:0]   strm_timeout;
        logic          is_open;
        logic [15:0]   want_seq;
        logic          held [WIN];
        logic [15:0]   held_tag [WIN];
        logic [31:0]   ticks_left;
        logic          armed;
        reorder_beat_t pending [$];
        int            errors;
        int            released;

        function new();
            buf_timeout = BUFFER_TIMEOUT_RESET;
            strm_timeout = STREAM_TIMEOUT_RESET;
            is_open = 0;
            want_seq = 0;
            ticks_left = 0;
            armed = 0;
            errors = 0;
            released = 0;
            for (int i = 0; i < WIN; i++)
            begin
                held[i] = 0;
                held_tag[i] = 0;
            end
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] val);
            if (idx == CFG_BUFFER_TIMEOUT)
                buf_timeout = val[15:0];
            else if (idx == CFG_STREAM_TIMEOUT)
                strm_timeout = val;
        endfunction

        function void push(logic [15:0] h, logic [15:0] s, logic [2:0] k);
            reorder_beat_t b;
            b.handle = h;
            b.seq = s;
            b.kind = k;
            b.last = 0;
            pending.push_back(b);
        endfunction

        function bit any_held();
            for (int i = 0; i < WIN; i++)
                if (held[i])
                    return 1;
            return 0;
        endfunction

        function void shift(int k);
            for (int i = 0; i < WIN; i++)
            begin
                if (i + k < WIN)
                begin
                    held[i] = held[i + k];
                    held_tag[i] = held_tag[i + k];
                end
                else
                    held[i] = 0;
            end
            want_seq = want_seq + 16'(k);
        endfunction

        function void drain();
            while (held[0])
            begin
                push(held_tag[0], want_seq, KIND_DELIVERED);
                shift(1);
            end
            armed = 1;
            ticks_left = any_held() ? {16'd0, buf_timeout} : strm_timeout;
        endfunction

        // Predict the beats caused by one accepted request.
        function void note_request(logic rt, logic [15:0] s, logic [15:0] h);
            int before_n;
            logic [15:0] d;
            int k;
            before_n = pending.size();
            if (rt == REQ_PACKET)
            begin
                if (!is_open)
                begin
                    is_open = 1;
                    want_seq = s;
                end
                d = s - want_seq;
                if (d == 0)
                begin
                    push(h, s, KIND_DELIVERED);
                    shift(1);
                    drain();
                end
                else if (d >= 16'h8000)
                    push(h, s, KIND_LATE);
                else if (d >= WIN)
                    push(h, s, KIND_BEYOND);
                else if (held[d])
                    push(h, s, KIND_DUP);
                else
                begin
                    if (!any_held())
                    begin
                        armed = 1;
                        ticks_left = {16'd0, buf_timeout};
                    end
                    held[d] = 1;
                    held_tag[d] = h;
                end
            end
            else if (is_open && armed)
            begin
                if (ticks_left > 1)
                    ticks_left--;
                else
                begin
                    ticks_left = 0;
                    k = WIN;
                    for (int i = WIN - 1; i >= 1; i--)
                        if (held[i])
                            k = i;
                    if (k == WIN)
                    begin
                        push(16'd0, want_seq, KIND_CLOSED);
                        is_open = 0;
                        armed = 0;
                    end
                    else
                    begin
                        shift(k);
                        drain();
                    end
                end
            end
            if (pending.size() > before_n)
                pending[pending.size() - 1].last = 1;
        endfunction

        function void check_beat(reorder_beat_t got);
            reorder_beat_t exp_b;
            if (pending.size() == 0)
            begin
                $error("unexpected result beat handle=%0h seq=%0h", got.handle, got.seq);
                errors++;
                return;
            end
            exp_b = pending.pop_front();
            released++;
            if (got.handle !== exp_b.handle)
            begin
                $error("out_handle expected %0h actual %0h", exp_b.handle, got.handle);
                errors++;
            end
            if (got.seq !== exp_b.seq)
            begin
                $error("out_seq expected %0h actual %0h", exp_b.seq, got.seq);
                errors++;
            end
            if (got.kind !== exp_b.kind)
            begin
                $error("out_kind expected %0d actual %0d", exp_b.kind, got.kind);
                errors++;
            end
            if (got.last !== exp_b.last)
            begin
                $error("out_last expected %0d actual %0d", exp_b.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [31:0]               cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic                      req_type;
    logic [15:0]               seq_number;
    logic [15:0]               packet_handle;
    logic                      out_valid;
    logic                      out_ready;
    logic [15:0]               out_handle;
    logic [15:0]               out_seq;
    logic [2:0]                out_kind;
    logic                      out_last;

    rtp_sequence_reorder_buffer uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .seq_number(seq_number), .packet_handle(packet_handle),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_handle(out_handle), .out_seq(out_seq), .out_kind(out_kind),
        .out_last(out_last)
    );

    reorder_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int stall_cycles;
    int packets_sent;
    int ticks_sent;
    logic [15:0] base_seq;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Output side: random stall, check at rising edge.
    initial
    begin
        out_ready = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_beat({out_handle, out_seq, out_kind, out_last});
            @(negedge clk);
            out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: cycles with no beat on either channel.
    initial
    begin
        stall_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Valid drops only on an idle cycle or in wait_idle, so back-to-back beats
    // see a single update per edge.
    task automatic send_req(logic rt, logic [15:0] s, logic [15:0] h);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        req_type <= rt;
        seq_number <= s;
        packet_handle <= h;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(rt, s, h);
        if (rt == REQ_TICK)
            ticks_sent++;
        else
            packets_sent++;
        @(negedge clk);
    endtask

    task automatic send_packet(logic [15:0] s);
        send_req(REQ_PACKET, s, 16'($urandom));
    endtask

    task automatic send_tick();
        send_req(REQ_TICK, 16'($urandom), 16'($urandom));
    endtask

    task automatic wait_idle();
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] val);
        wait_idle();
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        sb.write_reg(idx, val);
    endtask

    // Mostly near the expected number, some reordering, some noise.
    task automatic random_burst(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 12)
                send_tick();
            else if (r < 22)
                send_packet(16'($urandom));
            else if (r < 30)
                send_packet(sb.want_seq - 16'($urandom_range(1, 40)));
            else if (r < 34)
                send_packet(sb.want_seq + 16'($urandom_range(64, 200)));
            else if (r < 60)
                send_packet(sb.want_seq);
            else
                send_packet(sb.want_seq + 16'($urandom_range(1, 12)));
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 0;
        cfg_we = 0;
        cfg_index = CFG_BUFFER_TIMEOUT;
        cfg_data = 0;
        in_valid = 0;
        req_type = REQ_PACKET;
        seq_number = 0;
        packet_handle = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        packets_sent = 0;
        ticks_sent = 0;
        repeat (6) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: tick on closed stream, open, wrap, late, dup, beyond, fill.
        send_tick();
        send_req(REQ_PACKET, 16'hFFFE, 16'hFFFF);
        send_req(REQ_PACKET, 16'h0001, 16'h0000);
        send_req(REQ_PACKET, 16'h0001, 16'hA5A5);
        send_req(REQ_PACKET, 16'h7FFE, 16'h1234);
        send_req(REQ_PACKET, 16'h003D, 16'h5A5A);
        send_req(REQ_PACKET, 16'h003E, 16'h0F0F);
        send_req(REQ_PACKET, 16'hFFF0, 16'h00FF);
        send_req(REQ_PACKET, 16'hFFFF, 16'hFF00);
        send_req(REQ_PACKET, 16'hFFFE, 16'h3C3C);
        send_tick();
        send_tick();
        base_seq = sb.want_seq;
        for (int i = 1; i < WIN; i++)
            if (i % 9 == 0 || i > 58)
                send_packet(base_seq + 16'(i));
        send_packet(base_seq);
        send_tick();
        send_tick();

        set_reg(CFG_BUFFER_TIMEOUT, 32'd0);
        set_reg(CFG_STREAM_TIMEOUT, 32'd0);
        send_packet(16'h8000);
        send_packet(16'h8005);
        send_tick();
        send_tick();
        send_tick();

        for (int ph = 0; ph < 4; ph++)
        begin
            unique case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            set_reg(CFG_BUFFER_TIMEOUT, ph == 3 ? 32'hFFFF : 32'($urandom_range(0, 3)));
            set_reg(CFG_STREAM_TIMEOUT,
                    ph == 3 ? 32'hFFFF_FFFF : 32'($urandom_range(1, 6)));
            random_burst(93);
        end
        set_reg(CFG_BUFFER_TIMEOUT, 32'd2);
        set_reg(CFG_STREAM_TIMEOUT, 32'd1);
        repeat (8) send_tick();
        set_reg(CFG_SPARE_IDX, 32'd77);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_burst(20);
        wait_idle();

        $display("Covered %0d packets and %0d ticks, %0d result beats checked.",
                 packets_sent, ticks_sent, sb.released);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

[filelist.f]
hdl/rsrb_pkg.sv
hdl/rsrb_ctrl.sv
hdl/rsrb_dp.sv
hdl/rtp_sequence_reorder_buffer.sv
bench/tb_top.sv
